// File: rtl/table_linear_interpolator_unit_defines.svh
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tli_pkg.sv
package tli_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RD_PLO,
    S_RD_PHI,
    S_RD_VLO,
    S_RD_VHI,
    S_PREP,
    S_MUL,
    S_DIV,
    S_SUM,
    S_OUT
  } state_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BELOW    = 2'd1;
  localparam logic [1:0] REGION_ABOVE    = 2'd2;

  localparam logic REG_ENTRIES_USED = 1'b0;

  localparam int ENTRIES_USED_W = 7;

endpackage

// File: rtl/tli_if.sv
interface tli_req_if #(
  parameter int W = 48
);
  logic                valid;
  logic                ready;
  logic                func;
  logic [5:0]          entry_index;
  logic [3:0]          property_index;
  logic signed [W-1:0] load_value;
  logic signed [W-1:0] query_pressure;

  modport source (output valid, func, entry_index, property_index, load_value,
                  query_pressure, input ready);
  modport sink (input valid, func, entry_index, property_index, load_value,
                query_pressure, output ready);
endinterface

interface tli_rsp_if #(
  parameter int W = 48
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_value;
  logic [1:0]          region;
  logic                error_flag;

  modport source (output valid, result_value, region, error_flag, input ready);
  modport sink (input valid, result_value, region, error_flag, output ready);
endinterface

// File: rtl/table_linear_interpolator_unit.sv
// channel | direction | carries
// req     | in        | load of one table cell or a query (func selects)
// rsp     | out       | result_value, region, error_flag for each query
// apb     | in        | entries_used at byte address 0
//
// a load is written when it is accepted; a query's time from acceptance to a valid result
// is set by the row scan over the single table read port and the shared
// one-bit-per-cycle multiply and restoring divide. a bad column goes straight to the
// output state, and a zero span goes there from the operand preparation state.
// rst is synchronous; the table is not cleared, entries_used returns to 2.
// a finished result sits in the output register; a query that finishes while it
// is still held waits in the output state until rsp is taken.
`include "table_linear_interpolator_unit_defines.svh"

module table_linear_interpolator_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int NUM_COLUMNS = 14,
  parameter int VALUE_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  tli_req_if.sink           req,
  tli_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int W     = VALUE_WIDTH;
  localparam int DW    = W + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 2;
  localparam int DEPTH = MAX_ENTRIES * NUM_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(MAX_ENTRIES);
  localparam int CB    = $clog2(NUM_COLUMNS);
  localparam int NW    = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = $clog2(PW + 1);
  localparam int EW    = tli_pkg::ENTRIES_USED_W;

  tli_pkg::state_t state, state_next;

  logic [EW-1:0]       entries_used;
  logic [W-1:0]        mem [DEPTH];
  logic [AW-1:0]       raddr;
  logic [W-1:0]        rdata;

  logic [W-1:0]        p;
  logic [CB-1:0]       col;
  logic [NW-1:0]       n_eff;
  logic [RB-1:0]       idx, lo, hi;
  logic                use_hi;
  logic [1:0]          region;
  logic [W-1:0]        plo, phi, vlo, base;
  logic                neg;
  logic [DW-1:0]       mcand, dsor, rem;
  logic [PW-1:0]       prod;
  logic [CW-1:0]       cnt;
  logic [W-1:0]        res;
  logic                err;

  logic                ovalid;
  logic [W-1:0]        ovalue;
  logic [1:0]          oregion;
  logic                oerr;

  function automatic logic [AW-1:0] addr_of(input logic [RB-1:0] r, input logic [CB-1:0] c);
    addr_of = AW'(AW'(r) * AW'(NUM_COLUMNS) + AW'(c));
  endfunction

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    mag = x[DW-1] ? DW'(-x) : x;
  endfunction

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tli_pkg::REG_ENTRIES_USED) ? 32'(entries_used) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= EW'(2);
    end else if (psel && penable && pwrite && paddr[2] == tli_pkg::REG_ENTRIES_USED) begin
      entries_used <= pwdata[EW-1:0];
    end
  end

  logic in_acc, load_ok, col_ok;
  assign req.ready = (state == tli_pkg::S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign load_ok   = (32'(req.entry_index) < 32'(MAX_ENTRIES))
                  && (32'(req.property_index) < 32'(NUM_COLUMNS));
  assign col_ok    = 32'(req.property_index) < 32'(NUM_COLUMNS);

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (in_acc && req.func == tli_pkg::FUNC_LOAD && load_ok)
      mem[addr_of(RB'(req.entry_index), CB'(req.property_index))] <= req.load_value;
    rdata <= mem[raddr];
  end

  always_comb begin
    unique case (state)
      tli_pkg::S_SCAN_RD: raddr = addr_of(idx, '0);
      tli_pkg::S_RD_PLO:  raddr = addr_of(lo, '0);
      tli_pkg::S_RD_PHI:  raddr = addr_of(hi, '0);
      tli_pkg::S_RD_VLO:  raddr = addr_of(lo, col);
      tli_pkg::S_RD_VHI:  raddr = addr_of(hi, col);
      default:            raddr = '0;
    endcase
  end

  // scan compare
  logic less, last;
  assign less = $signed(rdata) < $signed(p);
  assign last = (NW'(idx) == NW'(n_eff - NW'(1)));

  // operand preparation, vhi arrives on rdata
  logic [W-1:0]  pb, bsel;
  logic [DW-1:0] dv, dp, span;
  assign pb   = use_hi ? phi : plo;
  assign bsel = use_hi ? rdata : vlo;
  assign dv   = DW'($signed({rdata[W-1], rdata}) - $signed({vlo[W-1], vlo}));
  assign dp   = DW'($signed({p[W-1], p}) - $signed({pb[W-1], pb}));
  assign span = DW'($signed({phi[W-1], phi}) - $signed({plo[W-1], plo}));

  // shared shift-add multiply and restoring divide step
  logic [DW:0]   msum;
  logic [DW:0]   trial;
  logic          qbit;
  assign msum  = {1'b0, prod[PW-1:DW]} + {1'b0, mcand};
  assign trial = {rem, prod[PW-1]};
  assign qbit  = trial >= {1'b0, dsor};

  // final sum and saturation
  logic [SW-1:0] qext, sum;
  logic          fits;
  assign qext = neg ? SW'(-{2'b00, prod}) : {2'b00, prod};
  assign sum  = {{(SW-W){base[W-1]}}, base} + qext;
  assign fits = (&sum[SW-1:W-1]) || !(|sum[SW-1:W-1]);

  always_ff @(posedge clk) begin
    if (rst) state <= tli_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tli_pkg::S_IDLE: begin
        if (in_acc && req.func == tli_pkg::FUNC_QUERY)
          state_next = col_ok ? tli_pkg::S_SCAN_RD : tli_pkg::S_OUT;
      end
      tli_pkg::S_SCAN_RD:  state_next = tli_pkg::S_SCAN_CMP;
      tli_pkg::S_SCAN_CMP: state_next = (less && !last) ? tli_pkg::S_SCAN_RD
                                                         : tli_pkg::S_RD_PLO;
      tli_pkg::S_RD_PLO:   state_next = tli_pkg::S_RD_PHI;
      tli_pkg::S_RD_PHI:   state_next = tli_pkg::S_RD_VLO;
      tli_pkg::S_RD_VLO:   state_next = tli_pkg::S_RD_VHI;
      tli_pkg::S_RD_VHI:   state_next = tli_pkg::S_PREP;
      tli_pkg::S_PREP:     state_next = (span == '0) ? tli_pkg::S_OUT : tli_pkg::S_MUL;
      tli_pkg::S_MUL:      if (cnt == CW'(DW - 1)) state_next = tli_pkg::S_DIV;
      tli_pkg::S_DIV:      if (cnt == CW'(PW - 1)) state_next = tli_pkg::S_SUM;
      tli_pkg::S_SUM:      state_next = tli_pkg::S_OUT;
      tli_pkg::S_OUT:      if (!ovalid || rsp.ready) state_next = tli_pkg::S_IDLE;
      default:             state_next = tli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tli_pkg::S_IDLE: begin
        p   <= req.query_pressure;
        col <= CB'(req.property_index);
        idx <= '0;
        res <= '0;
        err <= 1'b1;
        region <= tli_pkg::REGION_INTERIOR;
        priority if (32'(entries_used) < 32'd2)
          n_eff <= NW'(2);
        else if (32'(entries_used) > 32'(MAX_ENTRIES))
          n_eff <= NW'(MAX_ENTRIES);
        else
          n_eff <= NW'(entries_used);
      end
      tli_pkg::S_SCAN_CMP: begin
        priority if (less && !last) begin
          idx <= idx + RB'(1);
        end else if (less) begin
          region <= tli_pkg::REGION_ABOVE;
          lo <= RB'(n_eff - NW'(2));
          hi <= RB'(n_eff - NW'(1));
          use_hi <= 1'b1;
        end else if (idx == '0) begin
          region <= tli_pkg::REGION_BELOW;
          lo <= '0;
          hi <= RB'(1);
          use_hi <= 1'b0;
        end else begin
          region <= tli_pkg::REGION_INTERIOR;
          lo <= idx - RB'(1);
          hi <= idx;
          use_hi <= 1'b0;
        end
      end
      tli_pkg::S_RD_PHI: plo <= rdata;
      tli_pkg::S_RD_VLO: phi <= rdata;
      tli_pkg::S_RD_VHI: vlo <= rdata;
      tli_pkg::S_PREP: begin
        base  <= bsel;
        res   <= bsel;
        err   <= (span == '0);
        neg   <= dv[DW-1] ^ dp[DW-1] ^ span[DW-1];
        mcand <= mag(dv);
        prod  <= {{DW{1'b0}}, mag(dp)};
        dsor  <= mag(span);
        cnt   <= '0;
      end
      tli_pkg::S_MUL: begin
        prod <= prod[0] ? {msum, prod[DW-1:1]} : {1'b0, prod[PW-1:1]};
        cnt  <= (cnt == CW'(DW - 1)) ? '0 : cnt + CW'(1);
        rem  <= '0;
      end
      tli_pkg::S_DIV: begin
        rem  <= qbit ? DW'(trial - {1'b0, dsor}) : trial[DW-1:0];
        prod <= {prod[PW-2:0], qbit};
        cnt  <= cnt + CW'(1);
      end
      tli_pkg::S_SUM: begin
        if (fits) begin
          res <= sum[W-1:0];
          err <= 1'b0;
        end else begin
          res <= sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          err <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == tli_pkg::S_OUT && (!ovalid || rsp.ready)) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tli_pkg::S_OUT && (!ovalid || rsp.ready)) begin
      ovalue  <= res;
      oregion <= region;
      oerr    <= err;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.result_value = ovalue;
  assign rsp.region       = oregion;
  assign rsp.error_flag   = oerr;

  `TLI_ASSERT_NOW(a_div_nonzero, state == tli_pkg::S_DIV, dsor != '0, "divide by zero span")
  `TLI_ASSERT_NOW(a_mul_count, state == tli_pkg::S_MUL, cnt < CW'(DW), "multiply overrun")
  `TLI_ASSERT_NEXT(a_query_busy, in_acc && req.func == tli_pkg::FUNC_QUERY, !req.ready, "query not started")

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 64;
  localparam int COLS = 14;
  localparam int VW = 48;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [1:0] region;
    logic err;
  } answer_t;

  class interp_scoreboard;
    logic signed [VW-1:0] cells [ROWS][COLS];
    int rows_used;
    answer_t pending [$];
    int mismatches;
    int answers_seen;

    function new();
      rows_used = 2;
      mismatches = 0;
      answers_seen = 0;
    endfunction

    function void set_rows(int v);
      rows_used = v;
    endfunction

    function answer_t evaluate(logic [3:0] col, logic signed [VW-1:0] p);
      answer_t a;
      int n, i, lo, hi, b;
      logic signed [127:0] dv, dp, span, prod, q, sum, maxv, minv;
      maxv = (128'sd1 <<< (VW - 1)) - 1;
      minv = -(128'sd1 <<< (VW - 1));
      a = '0;
      if (col >= COLS) begin
        a.err = 1'b1;
        return a;
      end
      n = rows_used < 2 ? 2 : (rows_used > ROWS ? ROWS : rows_used);
      i = 0;
      while (i < n && cells[i][0] < p) i++;
      if (i == n) begin
        a.region = tli_pkg::REGION_ABOVE; lo = n - 2; hi = n - 1; b = n - 1;
      end else if (i == 0) begin
        a.region = tli_pkg::REGION_BELOW; lo = 0; hi = 1; b = 0;
      end else begin
        a.region = tli_pkg::REGION_INTERIOR; lo = i - 1; hi = i; b = i - 1;
      end
      dv = 128'(cells[hi][col]) - 128'(cells[lo][col]);
      dp = 128'(p) - 128'(cells[b][0]);
      span = 128'(cells[hi][0]) - 128'(cells[lo][0]);
      if (span == 0) begin
        a.value = cells[b][col];
        a.err = 1'b1;
      end else begin
        prod = dv * dp;
        q = prod / span;
        sum = 128'(cells[b][col]) + q;
        if (sum > maxv) begin
          a.value = maxv[VW-1:0]; a.err = 1'b1;
        end else if (sum < minv) begin
          a.value = minv[VW-1:0]; a.err = 1'b1;
        end else a.value = sum[VW-1:0];
      end
      return a;
    endfunction

    function void note_request(logic fn, logic [5:0] row, logic [3:0] col,
                               logic signed [VW-1:0] lv, logic signed [VW-1:0] p);
      if (fn == tli_pkg::FUNC_LOAD) begin
        if (col < COLS) cells[row][col] = lv;
      end else pending.insert(pending.size(), evaluate(col, p));
    endfunction

    function void check_answer(answer_t got);
      answer_t exp;
      answers_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction value=%0d", got.value);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value) begin
        $error("result_value expected %0d got %0d", exp.value, got.value);
        mismatches++;
      end
      if (got.region !== exp.region) begin
        $error("region expected %0d got %0d", exp.region, got.region);
        mismatches++;
      end
      if (got.err !== exp.err) begin
        $error("error_flag expected %0d got %0d", exp.err, got.err);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tli_req_if #(VW) req ();
  tli_rsp_if #(VW) rsp ();

  table_linear_interpolator_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  interp_scoreboard sb = new();
  longint cycles = 0;
  bit sink_idle_on = 1;
  bit src_idle_on = 1;
  bit hold_rsp = 0;
  int loads_sent = 0, queries_sent = 0;

  initial begin
    req.valid = 0; req.func = tli_pkg::FUNC_LOAD; req.entry_index = '0;
    req.property_index = '0; req.load_value = '0; req.query_pressure = '0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("table_linear_interpolator_unit verification failed");
      $finish;
    end
  end

  // result side: sample at the rising edge, change ready at the falling edge
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_answer('{rsp.result_value, rsp.region, rsp.error_flag});
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 0;
        @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        rsp.ready <= 0;
        repeat (gap) @(negedge clk);
      end else begin
        rsp.ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    req.valid <= 0;
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_rows(input int v);
    apb_write({tli_pkg::REG_ENTRIES_USED, 2'b00}, 32'(v));
    sb.set_rows(v & 7'h7f);
  endtask

  // offer one transaction, held until accepted; valid stays up for a following one
  task automatic send(input logic fn, input logic [5:0] row, input logic [3:0] col,
                      input logic signed [VW-1:0] lv, input logic signed [VW-1:0] p);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req.valid <= 1; req.func <= fn; req.entry_index <= row;
    req.property_index <= col; req.load_value <= lv; req.query_pressure <= p;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(fn, row, col, lv, p);
    if (fn == tli_pkg::FUNC_LOAD) loads_sent++;
    else queries_sent++;
    @(negedge clk);
  endtask

  task automatic load(input int row, input int col, input logic signed [VW-1:0] v);
    send(tli_pkg::FUNC_LOAD, row[5:0], col[3:0], v, 48'($urandom));
  endtask

  task automatic query(input int col, input logic signed [VW-1:0] p);
    send(tli_pkg::FUNC_QUERY, 6'($urandom), col[3:0], 48'({$urandom, $urandom}), p);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic signed [VW-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(VW-1){1'b1}}};
      1: return {1'b1, {(VW-1){1'b0}}};
      2: return VW'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  // fills rows 0..n-1 of every column, pressures non-decreasing
  task automatic fill_table(input int n, input bit wide_steps);
    logic signed [VW-1:0] pr;
    pr = wide_steps ? -(48'sd1 <<< 46) : -(48'sd100 <<< 16);
    for (int r = 0; r < n; r++) begin
      load(r, 0, pr);
      for (int c = 1; c < COLS; c++) load(r, c, rand_val());
      if ($urandom_range(0, 9) != 0)
        pr = pr + (wide_steps ? (48'sd1 <<< 40) + $urandom : 48'($urandom_range(1, 1 << 20)));
    end
  endtask

  function automatic logic signed [VW-1:0] pick_pressure(input int n);
    int r;
    r = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0: return sb.cells[r][0];
      1: return sb.cells[r][0] + 48'($urandom_range(0, 1 << 18)) - (48'sd1 <<< 17);
      2: return {1'b1, {(VW-1){1'b0}}};
      3: return {1'b0, {(VW-1){1'b1}}};
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  task automatic query_phase(input int n, input int count);
    int col;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: query($urandom_range(COLS, 15), pick_pressure(n));
        1: begin
          int row, c;
          row = $urandom_range(0, n - 1);
          c = $urandom_range(1, COLS - 1);
          load(row, c, rand_val());
        end
        2: load($urandom_range(0, 63), $urandom_range(COLS, 15), rand_val());
        default: begin
          col = $urandom_range(0, COLS - 1);
          query(col, pick_pressure(n));
        end
      endcase
    end
  endtask

  initial begin
    int sizes[$];
    int n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: two-row table, every region and special case
    fill_table(2, 0);
    query(1, sb.cells[0][0]);
    query(2, sb.cells[0][0] - (48'sd5 <<< 16));
    query(3, sb.cells[1][0] + (48'sd7 <<< 16));
    query(4, sb.cells[0][0] + 48'sd1);
    query(5, {1'b1, {(VW-1){1'b0}}});
    query(6, {1'b0, {(VW-1){1'b1}}});
    query(14, 48'sd0);
    query(15, 48'sd0);
    load(0, 15, 48'sd1);
    // zero span
    load(1, 0, sb.cells[0][0]);
    query(7, 48'sd0);
    // extreme values force saturation at the upper limit
    load(0, 0, {1'b1, {(VW-1){1'b0}}});
    load(1, 0, {1'b1, {(VW-2){1'b0}}, 1'b1});
    load(0, 13, {1'b1, {(VW-1){1'b0}}});
    load(1, 13, {1'b0, {(VW-1){1'b1}}});
    query(13, {1'b0, {(VW-1){1'b1}}});
    query(13, {1'b1, {(VW-1){1'b0}}});
    drain();

    // out-of-range register values clamp
    set_rows(0);
    query(1, 48'sd0);
    drain();
    set_rows(127);
    fill_table(64, 0);
    query_phase(64, 40);
    drain();

    sizes = '{2, 64, 3, 8, 64, 5, 2, 16, 33, 4};
    for (int ph = 0; ph < sizes.size(); ph++) begin
      n = sizes[ph];
      set_rows(n);
      if (ph == 4) begin
        // unsorted pressures in all rows
        for (int r = 0; r < n; r++) load(r, 0, rand_val());
      end else if (n <= 8) fill_table(n, ph % 2);
      if (ph == 3) begin
        // long receiver hold-off while queries keep coming
        fork
          begin
            hold_rsp = 1;
            repeat (600) @(negedge clk);
            hold_rsp = 0;
          end
          query_phase(n, 8);
        join
      end
      if (ph >= 8) begin
        sink_idle_on = 0;
        src_idle_on = 0;
      end
      query_phase(n, (ph < 2 ? 30 : 45));
      if (ph == 5) drain();
      drain();
    end

    drain();
    $display("covered %0d loads and %0d queries, %0d results compared",
             loads_sent, queries_sent, sb.answers_seen);
    $display("table sizes 0 to 127 programmed, saturation, zero span, bad columns");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("table_linear_interpolator_unit verification clean");
    end else begin
      $display("table_linear_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tli_pkg.sv
rtl/tli_if.sv
rtl/table_linear_interpolator_unit.sv
tb/sv/tb_top.sv
